@@ rtl/core/plte_pkg.sv @@
// ----------------------------------------------------------------------------
// plte_pkg
// Shared types and constants of the piecewise linear table evaluator.
// ----------------------------------------------------------------------------
`default_nettype none
package plte_pkg;

  // request codes
  localparam logic [2:0] REQ_CLEAR = 3'd0;
  localparam logic [2:0] REQ_LOAD  = 3'd1;
  localparam logic [2:0] REQ_EVAL  = 3'd2;
  localparam logic [2:0] REQ_INTEG = 3'd3;
  localparam logic [2:0] REQ_MEAN  = 3'd4;

  // status codes
  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_RANGE = 3'd1;
  localparam logic [2:0] ST_EMPTY = 3'd2;
  localparam logic [2:0] ST_ORDER = 3'd3;
  localparam logic [2:0] ST_FULL  = 3'd4;
  localparam logic [2:0] ST_ZERO  = 3'd5;

  // boundary modes
  localparam logic [1:0] BM_ZERO    = 2'd1;
  localparam logic [1:0] BM_CLOSEST = 2'd2;

  // divider request and reply
  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [32:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quo;
  } div_rsp_t;

  // unsigned 64-bit magnitude to a saturated signed 48-bit value
  function automatic logic [47:0] sat48(input logic neg, input logic [63:0] m);
    logic [47:0] r;
    begin
      if (neg) begin
        if (m > 64'h0000_8000_0000_0000) r = 48'h8000_0000_0000;
        else r = 48'(64'd0 - m);
      end else begin
        if (m > 64'h0000_7FFF_FFFF_FFFF) r = 48'h7FFF_FFFF_FFFF;
        else r = m[47:0];
      end
      return r;
    end
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/piecewise_linear_table_eval_core.sv @@
// ----------------------------------------------------------------------------
// piecewise_linear_table_eval_core
// Piecewise linear lookup table with trapezoid integral and weighted mean.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken when start is high and busy is low; busy rises the
//   cycle after and stays high until the result. The result appears for one
//   cycle with out_valid, in the same cycle that busy falls; the receiver
//   cannot stall, nothing is held back. Points sit in two single-port RAMs
//   (x and y) with a registered read. Clear and unknown requests go from
//   dispatch straight to done. Load reads the last point, then a 33x33
//   multiply, then writes; the first point is written in the dispatch state.
//   Integral is answered in the dispatch state. Evaluate: a binary search of
//   log2(MAX_POINTS)+1 probes, two reads of the bracket, a multiply and the
//   64-step bit-serial divider. Mean: 2 reads and the divider.
//   Configuration (boundary_mode) is written over cfg_valid/cfg_ready and
//   is ready at all times. Reset empties the table and zeroes the integral;
//   RAM contents are not cleared, nothing needs a clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none
module piecewise_linear_table_eval_core #(
  parameter int MAX_POINTS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output      logic        busy,
  input  wire logic [2:0]  in_req_type,
  input  wire logic signed [31:0] in_argument,
  input  wire logic signed [31:0] in_point_value,
  output      logic        out_valid,
  output      logic signed [47:0] out_result_value,
  output      logic [2:0]  out_status,
  input  wire logic        cfg_valid,
  output      logic        cfg_ready,
  input  wire logic [1:0]  cfg_boundary_mode
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b000_0000_0001,
    S_DISP  = 11'b000_0000_0010,
    S_LDRD  = 11'b000_0000_0100,
    S_LDMUL = 11'b000_0000_1000,
    S_SRCH  = 11'b000_0001_0000,
    S_SCHK  = 11'b000_0010_0000,
    S_BRK0  = 11'b000_0100_0000,
    S_BRK1  = 11'b000_1000_0000,
    S_EMUL  = 11'b001_0000_0000,
    S_DIV   = 11'b010_0000_0000,
    S_DONE  = 11'b100_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  // request capture
  logic [2:0]         req_r, req_nxt;
  logic signed [31:0] arg_r, arg_nxt;
  logic signed [31:0] pv_r, pv_nxt;

  // table state
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic signed [63:0] area_r, area_nxt;
  logic [1:0]         mode_r, mode_nxt;

  // search window [lo, hi) on point index; result first index with x > arg
  logic [CW-1:0] lo_r, lo_nxt, hi_r, hi_nxt;
  logic [CW-1:0] mid;

  // working values
  logic signed [31:0] x0_r, x0_nxt, y0_r, y0_nxt;
  logic               neg_r, neg_nxt;
  logic [63:0]        prod_r, prod_nxt;
  logic [32:0]        dx_r, dx_nxt;
  logic               prod_ok_r, prod_ok_nxt;

  // result
  logic [47:0] res_r, res_nxt;
  logic [2:0]  st_r, st_nxt;
  logic        ov_r, ov_nxt;

  // memory port
  logic          we;
  logic [AW-1:0] addr;
  logic [31:0]   xq, yq;

  // divider
  plte_pkg::div_req_t dreq;
  plte_pkg::div_rsp_t drsp;

  // datapath helpers
  logic signed [32:0] sum_s, diff_s;
  logic [32:0]        mag_s, off;
  logic [65:0]        mul;
  logic [63:0]        half, amag;
  logic signed [64:0] area_ext;

  // one spare bit keeps lo + hi from wrapping
  assign mid = CW'(({1'b0, lo_r} + {1'b0, hi_r}) >> 1);

  plte_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_xram (
    .clk(clk), .we(we), .addr(addr), .wdata(arg_r), .rdata(xq)
  );
  plte_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_yram (
    .clk(clk), .we(we), .addr(addr), .wdata(pv_r), .rdata(yq)
  );
  plte_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  assign amag = area_r[63] ? 64'd0 - 64'(area_r) : 64'(area_r);

  // control sequencer
  always_comb begin
    state_nxt   = state_r;
    req_nxt     = req_r;
    arg_nxt     = arg_r;
    pv_nxt      = pv_r;
    cnt_nxt     = cnt_r;
    area_nxt    = area_r;
    mode_nxt    = mode_r;
    lo_nxt      = lo_r;
    hi_nxt      = hi_r;
    x0_nxt      = x0_r;
    y0_nxt      = y0_r;
    neg_nxt     = neg_r;
    prod_nxt    = prod_r;
    dx_nxt      = dx_r;
    prod_ok_nxt = prod_ok_r;
    res_nxt     = res_r;
    st_nxt      = st_r;
    ov_nxt      = 1'b0;
    we          = 1'b0;
    addr        = '0;
    dreq.start  = 1'b0;
    dreq.num    = prod_r;
    dreq.den    = dx_r;
    sum_s       = '0;
    diff_s      = '0;
    mag_s       = '0;
    off         = '0;
    mul         = '0;
    half        = '0;
    area_ext    = '0;

    if (cfg_valid) mode_nxt = cfg_boundary_mode;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          req_nxt   = in_req_type;
          arg_nxt   = in_argument;
          pv_nxt    = in_point_value;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        res_nxt = '0;
        st_nxt  = plte_pkg::ST_OK;
        case (req_r)
          plte_pkg::REQ_CLEAR: begin
            cnt_nxt   = '0;
            area_nxt  = '0;
            state_nxt = S_DONE;
          end
          plte_pkg::REQ_LOAD: begin
            if (cnt_r >= CW'(MAX_POINTS)) begin
              st_nxt    = plte_pkg::ST_FULL;
              state_nxt = S_DONE;
            end else if (cnt_r == '0) begin
              we        = 1'b1;
              addr      = '0;
              cnt_nxt   = CW'(1);
              state_nxt = S_DONE;
            end else begin
              addr      = AW'(cnt_r - CW'(1));
              state_nxt = S_LDRD;
            end
          end
          plte_pkg::REQ_EVAL: begin
            if (cnt_r == '0) begin
              st_nxt    = plte_pkg::ST_EMPTY;
              state_nxt = S_DONE;
            end else begin
              lo_nxt    = '0;
              hi_nxt    = cnt_r;
              state_nxt = S_SRCH;
            end
          end
          plte_pkg::REQ_INTEG: begin
            if (cnt_r == '0) st_nxt = plte_pkg::ST_EMPTY;
            else res_nxt = plte_pkg::sat48(area_r[63], amag >> 16);
            state_nxt = S_DONE;
          end
          plte_pkg::REQ_MEAN: begin
            if (cnt_r == '0) begin
              st_nxt    = plte_pkg::ST_EMPTY;
              state_nxt = S_DONE;
            end else if (cnt_r < CW'(2)) begin
              st_nxt    = plte_pkg::ST_ZERO;
              state_nxt = S_DONE;
            end else begin
              addr      = '0;
              state_nxt = S_BRK0;
            end
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_LDRD: begin
        // last point ready: order check, then trapezoid product
        addr = AW'(cnt_r - CW'(1));
        if ($signed(arg_r) <= $signed(xq)) begin
          st_nxt    = plte_pkg::ST_ORDER;
          state_nxt = S_DONE;
        end else begin
          sum_s     = 33'(signed'(yq)) + 33'(signed'(pv_r));
          neg_nxt   = sum_s[32];
          x0_nxt    = signed'(xq);
          y0_nxt    = signed'(yq);
          state_nxt = S_LDMUL;
        end
      end
      S_LDMUL: begin
        sum_s  = 33'(y0_r) + 33'(pv_r);
        mag_s  = sum_s[32] ? 33'd0 - 33'(sum_s) : 33'(sum_s);
        diff_s = 33'(arg_r) - 33'(x0_r);
        mul    = 66'(mag_s) * 66'(diff_s);
        half   = 64'(mul >> 1);
        area_ext = neg_r ? 65'(area_r) - 65'(half) : 65'(area_r) + 65'(half);
        if (area_ext > 65'sh0_7FFF_FFFF_FFFF_FFFF) area_nxt = 64'h7FFF_FFFF_FFFF_FFFF;
        else if (area_ext < -65'sh0_8000_0000_0000_0000)
          area_nxt = 64'h8000_0000_0000_0000;
        else area_nxt = area_ext[63:0];
        we        = 1'b1;
        addr      = AW'(cnt_r);
        cnt_nxt   = cnt_r + CW'(1);
        state_nxt = S_DONE;
      end
      S_SRCH: begin
        if (lo_r == hi_r) begin
          if (lo_r == '0 || lo_r == cnt_r) begin
            if (mode_r == plte_pkg::BM_ZERO) begin
              state_nxt = S_DONE;
            end else if (mode_r == plte_pkg::BM_CLOSEST) begin
              addr      = (lo_r == '0) ? '0 : AW'(cnt_r - CW'(1));
              state_nxt = S_BRK1;
              lo_nxt    = '0;
            end else begin
              st_nxt    = plte_pkg::ST_RANGE;
              state_nxt = S_DONE;
            end
          end else begin
            addr      = AW'(lo_r - CW'(1));
            state_nxt = S_BRK0;
          end
        end else begin
          addr      = AW'(mid);
          state_nxt = S_SCHK;
        end
      end
      S_SCHK: begin
        if ($signed(xq) <= arg_r) lo_nxt = mid + CW'(1);
        else hi_nxt = mid;
        state_nxt = S_SRCH;
      end
      S_BRK0: begin
        // first point of bracket (or first point for mean)
        x0_nxt = signed'(xq);
        y0_nxt = signed'(yq);
        if (req_r == plte_pkg::REQ_MEAN) addr = AW'(cnt_r - CW'(1));
        else addr = AW'(lo_r);
        state_nxt = S_BRK1;
      end
      S_BRK1: begin
        if (req_r == plte_pkg::REQ_MEAN) begin
          dx_nxt   = 33'(signed'(xq)) - 33'(x0_r);
          prod_nxt = amag;
          neg_nxt  = area_r[63];
          prod_ok_nxt = 1'b1;
          state_nxt = S_EMUL;
        end else if (lo_r == '0 || lo_r == cnt_r) begin
          // closest end value
          res_nxt   = 48'(signed'(yq));
          state_nxt = S_DONE;
        end else begin
          diff_s   = 33'(signed'(yq)) - 33'(y0_r);
          neg_nxt  = diff_s[32];
          prod_nxt = 64'(diff_s[32] ? 33'd0 - 33'(diff_s) : 33'(diff_s));
          dx_nxt   = 33'(signed'(xq)) - 33'(x0_r);
          prod_ok_nxt = 1'b0;
          state_nxt = S_EMUL;
        end
      end
      S_EMUL: begin
        if (!prod_ok_r) begin
          off      = 33'(arg_r) - 33'(x0_r);
          prod_nxt = 64'(prod_r[32:0]) * 64'(off);
          prod_ok_nxt = 1'b1;
        end else if (dx_r == '0) begin
          st_nxt    = plte_pkg::ST_ZERO;
          state_nxt = S_DONE;
        end else begin
          dreq.start = 1'b1;
          state_nxt  = S_DIV;
        end
      end
      S_DIV: begin
        if (drsp.done) begin
          if (req_r == plte_pkg::REQ_MEAN)
            res_nxt = plte_pkg::sat48(neg_r, drsp.quo);
          else if (neg_r)
            res_nxt = 48'(signed'(y0_r)) - drsp.quo[47:0];
          else
            res_nxt = 48'(signed'(y0_r)) + drsp.quo[47:0];
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        ov_nxt    = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      area_r  <= '0;
      mode_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      area_r  <= area_nxt;
      mode_r  <= mode_nxt;
      ov_r    <= ov_nxt;
    end
    req_r     <= req_nxt;
    arg_r     <= arg_nxt;
    pv_r      <= pv_nxt;
    lo_r      <= lo_nxt;
    hi_r      <= hi_nxt;
    x0_r      <= x0_nxt;
    y0_r      <= y0_nxt;
    neg_r     <= neg_nxt;
    prod_r    <= prod_nxt;
    dx_r      <= dx_nxt;
    prod_ok_r <= prod_ok_nxt;
    res_r     <= res_nxt;
    st_r      <= st_nxt;
  end

  assign busy             = (state_r != S_IDLE);
  assign cfg_ready        = 1'b1;
  assign out_valid        = ov_r;
  assign out_result_value = signed'(res_r);
  assign out_status       = st_r;

endmodule
`default_nettype wire

@@ rtl/core/plte_ram.sv @@
// ----------------------------------------------------------------------------
// plte_ram
// Generic single-port RAM with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module plte_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

@@ rtl/core/plte_div.sv @@
// ----------------------------------------------------------------------------
// plte_div
// Restoring unsigned divider, 64-bit numerator by 33-bit divisor, one
// quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module plte_div (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire plte_pkg::div_req_t req,
  output      plte_pkg::div_rsp_t rsp
);

  logic [63:0] quo_r, quo_nxt;
  logic [33:0] rem_r, rem_nxt;
  logic [32:0] den_r, den_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [33:0] trial;

  // one shift-and-subtract step
  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r[32:0], quo_r[63]} - {1'b0, den_r};
    if (req.start) begin
      quo_nxt  = req.num;
      rem_nxt  = '0;
      den_nxt  = req.den;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[33]) begin
        rem_nxt = trial;
        quo_nxt = {quo_r[62:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[32:0], quo_r[63]};
        quo_nxt = {quo_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r + 7'd1;
      if (cnt_r == 7'd63) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

endmodule
`default_nettype wire

@@ rtl/core/plte_checker.sv @@
// ----------------------------------------------------------------------------
// plte_checker
// Port-level checks of the table evaluator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module plte_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        out_valid,
  input wire logic [47:0] out_result_value,
  input wire logic [2:0]  out_status
);

  // an accepted request makes the block busy
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("request not taken");

  // a result ends the busy period
  a_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("busy after result");

  // results are single-cycle strobes
  a_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result repeated");

  // an error result carries zero
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != plte_pkg::ST_OK) |-> (out_result_value == 48'd0))
    else $error("nonzero value on error");

endmodule

bind piecewise_linear_table_eval_core plte_checker u_plte_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_valid(out_valid), .out_result_value(out_result_value),
  .out_status(out_status)
);
`default_nettype wire

@@ sim/plte_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plte_scoreboard
// Watches the request, result and configuration channels of the table
// evaluator, predicts each result from its own copy of the table and
// compares the results in order, counting failures.
// ----------------------------------------------------------------------------
module plte_scoreboard #(
  parameter int MAX_POINTS = 64
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic               busy,
  input  wire logic [2:0]         in_req_type,
  input  wire logic signed [31:0] in_argument,
  input  wire logic signed [31:0] in_point_value,
  input  wire logic               out_valid,
  input  wire logic signed [47:0] out_result_value,
  input  wire logic [2:0]         out_status,
  input  wire logic               cfg_valid,
  input  wire logic               cfg_ready,
  input  wire logic [1:0]         cfg_boundary_mode,
  output int                      pending,
  output int                      fail_count
);

  typedef struct {
    logic signed [47:0] value;
    logic [2:0]         status;
  } answer_t;

  // model copy of the table
  longint      tab_x [MAX_POINTS];
  longint      tab_y [MAX_POINTS];
  int          n_points;
  longint      area_q32;
  logic [1:0]  mode;
  answer_t     answers_due [$];
  int          mismatches;

  function automatic longint magnitude(longint v);
    return (v < 0) ? -v : v;
  endfunction

  // signed magnitude clamped into 48 bits
  function automatic logic signed [47:0] clamp48(logic neg, logic [63:0] m);
    if (neg) begin
      if (m > 64'h0000_8000_0000_0000) return 48'sh8000_0000_0000;
      return 48'(-m);
    end
    if (m > 64'h0000_7FFF_FFFF_FFFF) return 48'sh7FFF_FFFF_FFFF;
    return m[47:0];
  endfunction

  // apply one request to the model and work out its answer
  task automatic apply_request(input logic [2:0] req, input longint a, input longint p,
                               output answer_t ans);
    longint      s;
    longint      dx;
    logic [63:0] prod;
    logic [63:0] um;
    logic [63:0] uo;
    logic [63:0] ud;
    longint      t;
    logic signed [64:0] sum65;
    int          i;
    longint      dy;
    ans.value  = '0;
    ans.status = plte_pkg::ST_OK;
    case (req)
      plte_pkg::REQ_CLEAR: begin
        n_points = 0;
        area_q32 = 0;
      end
      plte_pkg::REQ_LOAD: begin
        if (n_points >= MAX_POINTS) begin
          ans.status = plte_pkg::ST_FULL;
        end else if (n_points > 0 && a <= tab_x[n_points-1]) begin
          ans.status = plte_pkg::ST_ORDER;
        end else begin
          if (n_points > 0) begin
            s    = tab_y[n_points-1] + p;
            dx   = a - tab_x[n_points-1];
            um   = 64'(magnitude(s));
            ud   = 64'(dx);
            prod = (um * ud) >> 1;
            t    = (s < 0) ? -longint'(prod) : longint'(prod);
            sum65 = 65'(area_q32) + 65'(t);
            if (sum65 > 65'sh0_7FFF_FFFF_FFFF_FFFF) area_q32 = 64'h7FFF_FFFF_FFFF_FFFF;
            else if (sum65 < -65'sh0_8000_0000_0000_0000) area_q32 = 64'h8000_0000_0000_0000;
            else area_q32 = sum65[63:0];
          end
          tab_x[n_points] = a;
          tab_y[n_points] = p;
          n_points++;
        end
      end
      plte_pkg::REQ_EVAL: begin
        if (n_points == 0) begin
          ans.status = plte_pkg::ST_EMPTY;
        end else begin
          i = 0;
          while (i < n_points && tab_x[i] <= a) i++;
          if (i == 0 || i == n_points) begin
            // outside the table: boundary handling
            if (mode == plte_pkg::BM_CLOSEST)
              ans.value = 48'((i == 0) ? tab_y[0] : tab_y[n_points-1]);
            else if (mode != plte_pkg::BM_ZERO)
              ans.status = plte_pkg::ST_RANGE;
          end else begin
            dy   = tab_y[i] - tab_y[i-1];
            // unsigned product: it can pass 2^63
            um   = 64'(magnitude(dy));
            uo   = 64'(a - tab_x[i-1]);
            ud   = 64'(tab_x[i] - tab_x[i-1]);
            prod = (um * uo) / ud;
            ans.value = 48'((dy < 0) ? tab_y[i-1] - longint'(prod)
                                     : tab_y[i-1] + longint'(prod));
          end
        end
      end
      plte_pkg::REQ_INTEG: begin
        if (n_points == 0) ans.status = plte_pkg::ST_EMPTY;
        else ans.value = clamp48(area_q32 < 0, 64'(magnitude(area_q32)) >> 16);
      end
      plte_pkg::REQ_MEAN: begin
        if (n_points == 0) begin
          ans.status = plte_pkg::ST_EMPTY;
        end else if (n_points < 2 || tab_x[n_points-1] == tab_x[0]) begin
          ans.status = plte_pkg::ST_ZERO;
        end else begin
          um   = 64'(magnitude(area_q32));
          ud   = 64'(tab_x[n_points-1] - tab_x[0]);
          prod = um / ud;
          ans.value = clamp48(area_q32 < 0, prod);
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    answer_t fresh;
    answer_t due;
    if (!rst_n) begin
      n_points = 0;
      area_q32 = 0;
      mode     = 2'd0;
      answers_due.delete();
    end else begin
      // results first: a request accepted at this edge cannot answer at it
      if (out_valid) begin
        if (answers_due.size() == 0) begin
          fail_count++;
          if (mismatches++ < 10)
            $display("unexpected result value=%0d status=%0d", out_result_value, out_status);
        end else begin
          due = answers_due.pop_front();
          if (out_result_value !== due.value || out_status !== due.status) begin
            fail_count++;
            if (mismatches++ < 10)
              $display("mismatch: expected value=%0d status=%0d, got value=%0d status=%0d",
                       due.value, due.status, out_result_value, out_status);
          end
        end
      end
      if (start && !busy) begin
        apply_request(in_req_type, longint'(in_argument), longint'(in_point_value), fresh);
        answers_due.insert(answers_due.size(), fresh);
      end
      if (cfg_valid && cfg_ready) mode = cfg_boundary_mode;
    end
    pending = answers_due.size();
  end

  initial begin
    pending    = 0;
    fail_count = 0;
    mismatches = 0;
  end

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives directed and random request sequences and boundary mode changes
// into the table evaluator; the scoreboard predicts and compares the results.
// ----------------------------------------------------------------------------
module tb_top;

  localparam logic [1:0] BM_STRICT   = 2'd0;
  localparam logic [1:0] BM_RESERVED = 2'd3;
  localparam logic [2:0] REQ_UNUSED  = 3'd7;
  localparam int         CYCLE_LIMIT = 600000;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [2:0]         in_req_type;
  logic signed [31:0] in_argument;
  logic signed [31:0] in_point_value;
  logic               out_valid;
  logic signed [47:0] out_result_value;
  logic [2:0]         out_status;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [1:0]         cfg_boundary_mode;
  int                 pending;
  int                 fail_count;
  int                 cycles;
  int                 requests_sent;

  piecewise_linear_table_eval_core i_dut (
    .clk, .rst_n, .start, .busy, .in_req_type, .in_argument, .in_point_value,
    .out_valid, .out_result_value, .out_status, .cfg_valid, .cfg_ready,
    .cfg_boundary_mode
  );

  plte_scoreboard i_checker (
    .clk, .rst_n, .start, .busy, .in_req_type, .in_argument, .in_point_value,
    .out_valid, .out_result_value, .out_status, .cfg_valid, .cfg_ready,
    .cfg_boundary_mode, .pending, .fail_count
  );

  always begin
    clk = 1'b1; #1;
    clk = 1'b0; #1;
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[piecewise_linear_table_eval_core] ERROR");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // one request; returns at the falling edge after it was taken
  task automatic send_request(input logic [2:0] req, input logic [31:0] a,
                              input logic [31:0] p);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_req_type    = req;
    in_argument    = a;
    in_point_value = p;
    start          = 1'b1;
    do @(posedge clk); while (busy);
    @(negedge clk);
    requests_sent++;
  endtask

  // boundary mode change, only with nothing in flight
  task automatic write_mode(input logic [1:0] m);
    start = 1'b0;
    while (pending != 0) @(negedge clk);
    cfg_boundary_mode = m;
    cfg_valid         = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // clear, then a run of mostly ascending points, then queries, mostly around them
  task automatic random_sequence();
    longint x;
    longint x_first;
    longint x_last;
    int     k;
    int     q;
    int     r;
    longint step_max;
    send_request(plte_pkg::REQ_CLEAR, $urandom, $urandom);
    r = $urandom_range(0, 19);
    k = (r == 0) ? $urandom_range(64, 67) : $urandom_range(1, 8);
    step_max = (k > 8) ? 64'd1000000 :
               ($urandom_range(0, 3) == 0) ? 64'd2000000000 : 64'd300000;
    x = longint'($signed(32'($urandom))) / ((k > 8) ? 4 : 2);
    x_first = x;
    x_last  = x;
    for (int j = 0; j < k; j++) begin
      if ($urandom_range(0, 14) == 0 && j > 0) begin
        // out of order or duplicate x
        send_request(plte_pkg::REQ_LOAD, 32'(x_last - $urandom_range(0, 5)), $urandom);
      end else begin
        if (x > 64'sd2147483647) break;
        send_request(plte_pkg::REQ_LOAD, 32'(x), $urandom);
        x_last = x;
      end
      x = x + 1 + ($urandom % step_max);
    end
    q = $urandom_range(2, 8);
    for (int j = 0; j < q; j++) begin
      r = $urandom_range(0, 9);
      if (r < 6) begin
        x = x_first - 1000 + $urandom_range(0, 1000) +
            ((x_last - x_first + 2000) * $urandom_range(0, 1000)) / 1000;
        send_request(plte_pkg::REQ_EVAL, 32'(x), $urandom);
      end else if (r == 6) begin
        send_request(plte_pkg::REQ_EVAL, $urandom, $urandom);
      end else if (r == 7) begin
        send_request(plte_pkg::REQ_INTEG, $urandom, $urandom);
      end else if (r == 8) begin
        send_request(plte_pkg::REQ_MEAN, $urandom, $urandom);
      end else begin
        send_request(3'($urandom_range(5, 7)), $urandom, $urandom);
      end
    end
  endtask

  initial begin
    int wait_cycles;
    cycles            = 0;
    requests_sent     = 0;
    rst_n             = 1'b0;
    start             = 1'b0;
    in_req_type       = plte_pkg::REQ_CLEAR;
    in_argument       = '0;
    in_point_value    = '0;
    cfg_valid         = 1'b0;
    cfg_boundary_mode = BM_STRICT;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: empty table, single point, order checks, extremes
    send_request(plte_pkg::REQ_EVAL, 32'h0, 32'h0);
    send_request(plte_pkg::REQ_INTEG, 32'h0, 32'h0);
    send_request(plte_pkg::REQ_MEAN, 32'h0, 32'h0);
    send_request(plte_pkg::REQ_LOAD, 32'h8000_0000, 32'h8000_0000);
    send_request(plte_pkg::REQ_INTEG, 32'h0, 32'h0);
    send_request(plte_pkg::REQ_MEAN, 32'h0, 32'h0);
    send_request(plte_pkg::REQ_EVAL, 32'h8000_0000, 32'h0);
    send_request(plte_pkg::REQ_LOAD, 32'h8000_0000, 32'h0);
    send_request(plte_pkg::REQ_LOAD, 32'h7FFF_FFFF, 32'h8000_0000);
    send_request(plte_pkg::REQ_LOAD, 32'h0, 32'h0);
    send_request(plte_pkg::REQ_EVAL, 32'h0, 32'h0);
    send_request(plte_pkg::REQ_EVAL, 32'h7FFF_FFFE, 32'h0);
    send_request(plte_pkg::REQ_EVAL, 32'h7FFF_FFFF, 32'h0);
    send_request(plte_pkg::REQ_INTEG, 32'h0, 32'h0);
    send_request(plte_pkg::REQ_MEAN, 32'h0, 32'h0);
    send_request(REQ_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    write_mode(plte_pkg::BM_CLOSEST);
    send_request(plte_pkg::REQ_EVAL, 32'h7FFF_FFFF, 32'h0);
    send_request(plte_pkg::REQ_CLEAR, 32'h0, 32'h0);
    send_request(plte_pkg::REQ_LOAD, 32'hFFFF_0000, 32'h7FFF_FFFF);
    send_request(plte_pkg::REQ_LOAD, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_request(plte_pkg::REQ_EVAL, 32'h8000_0000, 32'h0);
    send_request(plte_pkg::REQ_INTEG, 32'h0, 32'h0);
    send_request(plte_pkg::REQ_MEAN, 32'h0, 32'h0);
    write_mode(plte_pkg::BM_ZERO);
    send_request(plte_pkg::REQ_EVAL, 32'h8000_0000, 32'h0);
    write_mode(BM_RESERVED);
    send_request(plte_pkg::REQ_EVAL, 32'h8000_0000, 32'h0);

    // random sequences with occasional mode changes
    while (requests_sent < 390) begin
      if ($urandom_range(0, 5) == 0) write_mode(2'($urandom_range(0, 3)));
      if ($urandom_range(0, 9) == 0)
        send_request(3'($urandom), $urandom, $urandom);
      else
        random_sequence();
    end
    start = 1'b0;

    // drain
    while (pending != 0) @(negedge clk);
    wait_cycles = 0;
    while (wait_cycles < 100) begin
      @(negedge clk);
      wait_cycles++;
    end
    if (fail_count == 0 && pending == 0) begin
      $display("[piecewise_linear_table_eval_core] OK");
    end else begin
      $display("[piecewise_linear_table_eval_core] ERROR");
    end
    $finish;
  end

endmodule
